>>> hw/rtl/dsvtn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dsvtn_pkg;

  localparam int MasterClock = 7159000;
  localparam int PhaseWrap   = 24000;
  localparam int LevelGain   = 90;

  localparam logic [13:0] BASE_STEP   = 14'(MasterClock / 512);
  localparam logic [14:0] NOISE_FAST  = 15'(MasterClock / 256);
  localparam logic [14:0] NOISE_MID   = 15'(MasterClock / 512);
  localparam logic [14:0] NOISE_SLOW  = 15'(MasterClock / 1024);
  localparam logic [15:0] WRAP16      = 16'(PhaseWrap);
  localparam logic [13:0] GAIN14      = 14'(LevelGain);
  localparam logic [8:0]  NOTE_TOP    = 9'd511;
  localparam logic [4:0]  DIV_LAST    = 5'd20;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [4:0] REG_VOL_LAST  = 5'h05;
  localparam logic [4:0] REG_NOTE_LO   = 5'h08;
  localparam logic [4:0] REG_NOTE_HI   = 5'h0D;
  localparam logic [4:0] REG_OCT_LO    = 5'h10;
  localparam logic [4:0] REG_OCT_HI    = 5'h12;
  localparam logic [4:0] REG_TONE_EN   = 5'h14;
  localparam logic [4:0] REG_NOISE_EN  = 5'h15;
  localparam logic [4:0] REG_NOISE_SEL = 5'h16;
  localparam logic [4:0] REG_CHIP_EN   = 5'h1C;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRITE_LATCH,
    OP_WRITE_REG,
    OP_READ_REQ,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_TONE,
    OP_NOISE,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       chip;
    logic [2:0] voice;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       latch_sel;
    logic       chip;
    logic [4:0] reg_addr;
    logic [1:0] chip_en;
  } status_t;

  function automatic logic is_note_reg(input logic [4:0] a);
    return (a >= REG_NOTE_LO) && (a <= REG_NOTE_HI);
  endfunction

  function automatic logic is_oct_reg(input logic [4:0] a);
    return (a >= REG_OCT_LO) && (a <= REG_OCT_HI);
  endfunction

  function automatic logic [3:0] voice_index(input logic chip, input logic [2:0] d);
    return chip ? (4'(d) + 4'd6) : 4'(d);
  endfunction

  function automatic logic [15:0] lfsr_step(input logic [15:0] x);
    logic [15:0] s;
    s = {x[14:0], 1'b0};
    if (s[14] == s[6]) begin
      s[0] = 1'b1;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dsvtn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dsvtn_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire               out_stall,
  input  dsvtn_pkg::status_t status,
  output dsvtn_pkg::cmd_t    cmd
);
  import dsvtn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DIV_START, S_DIV_STEP, S_DIV_STORE,
    S_CHIP, S_TONE, S_NOISE, S_OUT
  } state_t;

  state_t     state;
  logic       chip;
  logic [2:0] voice;
  logic [4:0] div_cnt;
  logic       second;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // command decode
  always_comb begin
    cmd.chip  = chip;
    cmd.voice = voice;
    cmd.op    = OP_NONE;
    case (state)
      S_IDLE:      if (in_valid) cmd.op = OP_LOAD;
      S_DECODE: begin
        case (status.mode)
          MODE_WRITE: cmd.op = status.latch_sel ? OP_WRITE_LATCH : OP_WRITE_REG;
          MODE_READ:  cmd.op = OP_READ_REQ;
          default:    cmd.op = OP_NONE;
        endcase
      end
      S_DIV_START: cmd.op = OP_DIV_START;
      S_DIV_STEP:  cmd.op = OP_DIV_STEP;
      S_DIV_STORE: cmd.op = OP_DIV_STORE;
      S_TONE:      cmd.op = OP_TONE;
      S_NOISE:     cmd.op = OP_NOISE;
      S_OUT:       if (out_free) cmd.op = OP_OUT;
      default:     cmd.op = OP_NONE;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chip      <= 1'b0;
      voice     <= 3'd0;
      div_cnt   <= 5'd0;
      second    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result handshake
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          case (status.mode)
            MODE_WRITE: begin
              chip <= status.chip;
              if (!status.latch_sel && is_note_reg(status.reg_addr)) begin
                voice  <= status.reg_addr[2:0];
                second <= 1'b0;
                state  <= S_DIV_START;
              end else if (!status.latch_sel && is_oct_reg(status.reg_addr)) begin
                voice  <= {status.reg_addr[1:0], 1'b0};
                second <= 1'b1;
                state  <= S_DIV_START;
              end else begin
                state <= S_OUT;
              end
            end
            MODE_TICK: begin
              chip  <= 1'b0;
              state <= S_CHIP;
            end
            default:   state <= S_OUT;
          endcase
        end
        S_DIV_START: begin
          div_cnt <= 5'd0;
          state   <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == DIV_LAST) state <= S_DIV_STORE;
        end
        S_DIV_STORE: begin
          if (second) begin
            second <= 1'b0;
            voice  <= voice + 3'd1;
            state  <= S_DIV_START;
          end else begin
            state <= S_OUT;
          end
        end
        S_CHIP: begin
          voice <= 3'd0;
          if (status.chip_en[chip]) begin
            state <= S_TONE;
          end else if (chip) begin
            state <= S_OUT;
          end else begin
            chip <= 1'b1;
          end
        end
        S_TONE: begin
          if (voice == 3'd5) begin
            voice <= 3'd0;
            state <= S_NOISE;
          end else begin
            voice <= voice + 3'd1;
          end
        end
        S_NOISE: begin
          if (voice == 3'd1) begin
            if (chip) begin
              state <= S_OUT;
            end else begin
              chip  <= 1'b1;
              state <= S_CHIP;
            end
          end else begin
            voice <= voice + 3'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/dsvtn_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module dsvtn_dp (
  input  wire               clk,
  input  wire               rst,
  input  wire  [1:0]        mode,
  input  wire  [1:0]        bus_address,
  input  wire  [7:0]        write_data,
  input  dsvtn_pkg::cmd_t    cmd,
  output dsvtn_pkg::status_t status,
  output logic [7:0]        read_data,
  output logic [13:0]       left_sample,
  output logic [13:0]       right_sample
);
  import dsvtn_pkg::*;

  // captured transaction
  logic [1:0] it_mode;
  logic [1:0] it_addr;
  logic [7:0] it_data;

  logic [4:0]  latch [2];
  logic [7:0]  vol [12];
  logic [5:0]  tone_en [2];
  logic [5:0]  noise_en [2];
  logic [5:0]  noise_sel [2];
  logic [1:0]  chip_en;
  logic [7:0]  note [12];
  logic [2:0]  oct [12];
  logic [12:0] phase_step [12];
  logic [14:0] phase_count [12];
  logic [11:0] tone_level;
  logic [15:0] noise_shift [4];
  logic [14:0] noise_count [4];
  logic [13:0] acc_l;
  logic [13:0] acc_r;

  // register file memory with valid bits
  logic [7:0]  mem [64];
  logic [63:0] mem_vld;
  logic [7:0]  mem_q;
  logic        mem_q_vld;

  // divider
  logic [20:0] dvd;
  logic [8:0]  dvs;
  logic [8:0]  rem;
  logic [12:0] quo;
  logic [9:0]  rem_sh;

  logic       chip;
  logic [4:0] a;
  logic [5:0] mem_idx;
  logic [3:0] v;
  logic [3:0] vn;
  logic [3:0] vo;
  logic [1:0] ns;

  assign chip    = it_addr[1];
  assign a       = latch[chip];
  assign mem_idx = {chip, a};
  assign v       = voice_index(cmd.chip, cmd.voice);
  assign vn      = voice_index(chip, a[2:0]);
  assign vo      = voice_index(chip, {a[1:0], 1'b0});
  assign ns      = {cmd.chip, cmd.voice[0]};

  assign status.mode      = it_mode;
  assign status.latch_sel = it_addr[0];
  assign status.chip      = chip;
  assign status.reg_addr  = a;
  assign status.chip_en   = chip_en;

  assign rem_sh = {rem, dvd[20]};

  // tone voice terms
  logic [13:0] gain_l;
  logic [13:0] gain_r;
  logic [15:0] pc_sum;
  logic        pc_wrap;
  logic        tone_on;
  logic        noise_on;
  logic        noise_bit;

  always_comb begin
    gain_l    = 14'(vol[v][3:0]) * GAIN14;
    gain_r    = 14'(vol[v][7:4]) * GAIN14;
    pc_sum    = {1'b0, phase_count[v]} + {3'b000, phase_step[v]};
    pc_wrap   = pc_sum >= WRAP16;
    tone_on   = tone_en[cmd.chip][cmd.voice];
    noise_on  = noise_en[cmd.chip][cmd.voice];
    noise_bit = noise_shift[{cmd.chip, cmd.voice >= 3'd3}][0];
  end

  // noise source terms, at most two wraps per tick
  logic [1:0]  sel;
  logic [14:0] rate;
  logic [15:0] n_sum;
  logic [15:0] n_one;
  logic [15:0] n_two;
  logic [15:0] sh_one;
  logic [15:0] sh_two;

  always_comb begin
    sel = cmd.voice[0] ? noise_sel[cmd.chip][5:4] : noise_sel[cmd.chip][1:0];
    case (sel)
      2'd0:    rate = NOISE_FAST;
      2'd1:    rate = NOISE_MID;
      2'd2:    rate = NOISE_SLOW;
      default: rate = {2'b00, phase_step[voice_index(cmd.chip, {cmd.voice[0], 2'b00})
                       - {2'b00, cmd.voice[0], 1'b0} + {3'b000, cmd.voice[0]}]};
    endcase
    n_sum  = {1'b0, noise_count[ns]} + {1'b0, rate};
    n_one  = n_sum;
    sh_one = noise_shift[ns];
    if (n_sum >= WRAP16) begin
      n_one  = n_sum - WRAP16;
      sh_one = lfsr_step(noise_shift[ns]);
    end
    n_two  = n_one;
    sh_two = sh_one;
    if (n_one >= WRAP16) begin
      n_two  = n_one - WRAP16;
      sh_two = lfsr_step(sh_one);
    end
  end

  // memory port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE_REG) begin
      mem[mem_idx] <= it_data;
    end
    if (cmd.op == OP_READ_REQ) begin
      mem_q     <= mem[mem_idx];
      mem_q_vld <= mem_vld[mem_idx];
    end
  end

  // datapath state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        latch[i]     <= 5'd0;
        tone_en[i]   <= 6'd0;
        noise_en[i]  <= 6'd0;
        noise_sel[i] <= 6'd0;
      end
      for (int i = 0; i < 12; i++) begin
        vol[i]         <= 8'd0;
        note[i]        <= 8'd0;
        oct[i]         <= 3'd0;
        phase_step[i]  <= 13'd0;
        phase_count[i] <= 15'd0;
      end
      for (int i = 0; i < 4; i++) begin
        noise_shift[i] <= 16'd0;
        noise_count[i] <= 15'd0;
      end
      chip_en      <= 2'b00;
      tone_level   <= 12'd0;
      mem_vld      <= 64'd0;
      acc_l        <= 14'd0;
      acc_r        <= 14'd0;
      it_mode      <= 2'd0;
      it_addr      <= 2'd0;
      it_data      <= 8'd0;
      read_data    <= 8'd0;
      left_sample  <= 14'd0;
      right_sample <= 14'd0;
      dvd          <= 21'd0;
      dvs          <= 9'd0;
      rem          <= 9'd0;
      quo          <= 13'd0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          it_mode <= mode;
          it_addr <= bus_address;
          it_data <= write_data;
          acc_l   <= 14'd0;
          acc_r   <= 14'd0;
        end
        OP_WRITE_LATCH: latch[chip] <= it_data[4:0];
        OP_WRITE_REG: begin
          mem_vld[mem_idx] <= 1'b1;
          if (a <= REG_VOL_LAST) vol[vn] <= it_data;
          if (a == REG_TONE_EN)   tone_en[chip]   <= it_data[5:0];
          if (a == REG_NOISE_EN)  noise_en[chip]  <= it_data[5:0];
          if (a == REG_NOISE_SEL) noise_sel[chip] <= it_data[5:0];
          if (a == REG_CHIP_EN)   chip_en[chip]   <= it_data[0];
          if (is_note_reg(a)) note[vn] <= it_data;
          if (is_oct_reg(a)) begin
            oct[vo]        <= it_data[2:0];
            oct[vo + 4'd1] <= it_data[6:4];
          end
        end
        OP_DIV_START: begin
          dvd <= 21'(BASE_STEP) << oct[v];
          dvs <= NOTE_TOP - {1'b0, note[v]};
          rem <= 9'd0;
          quo <= 13'd0;
        end
        OP_DIV_STEP: begin
          dvd <= {dvd[19:0], 1'b0};
          if (rem_sh >= {1'b0, dvs}) begin
            rem <= 9'(rem_sh - {1'b0, dvs});
            quo <= {quo[11:0], 1'b1};
          end else begin
            rem <= rem_sh[8:0];
            quo <= {quo[11:0], 1'b0};
          end
        end
        OP_DIV_STORE: phase_step[v] <= quo;
        OP_TONE: begin
          if (tone_on) begin
            if (tone_level[v]) begin
              acc_l <= acc_l + gain_l;
              acc_r <= acc_r + gain_r;
            end
            if (pc_wrap) begin
              phase_count[v] <= 15'(pc_sum - WRAP16);
              tone_level[v]  <= !tone_level[v];
            end else begin
              phase_count[v] <= pc_sum[14:0];
            end
          end else if (noise_on && noise_bit) begin
            acc_l <= acc_l + gain_l;
            acc_r <= acc_r + gain_r;
          end
        end
        OP_NOISE: begin
          noise_count[ns] <= n_two[14:0];
          noise_shift[ns] <= sh_two;
        end
        OP_OUT: begin
          if (it_mode == MODE_READ) begin
            read_data <= it_addr[0] ? {3'b000, a} : (mem_q_vld ? mem_q : 8'd0);
          end else begin
            read_data <= 8'd0;
          end
          left_sample  <= (it_mode == MODE_TICK) ? acc_l : 14'd0;
          right_sample <= (it_mode == MODE_TICK) ? acc_r : 14'd0;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/dual_six_voice_tone_noise_generator.sv
// sequence: a latch write, read or unused mode goes straight to the result; a note write runs
//   the divider for one voice, an octave write for two (21-step restoring divider, one bit a cycle)
// tick: per enabled chip, six voices and two noise sources, one a cycle
// throughput: one transaction at a time, next accepted once the result is registered
// reset: synchronous rst clears all voice, noise and latch state and the register valid bits to zero
`timescale 1ns / 1ps
`default_nettype none
module dual_six_voice_tone_noise_generator (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  mode,
  input  wire  [1:0]  bus_address,
  input  wire  [7:0]  write_data,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  read_data,
  output logic [13:0] left_sample,
  output logic [13:0] right_sample
);
  import dsvtn_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  dsvtn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // voice, noise and register datapath
  dsvtn_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .bus_address  (bus_address),
    .write_data   (write_data),
    .cmd          (cmd),
    .status       (status),
    .read_data    (read_data),
    .left_sample  (left_sample),
    .right_sample (right_sample)
  );

endmodule
`default_nettype wire
